FILE: src/interarrival_cv_window_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the interarrival CV window block
// Implication checks on the rising clock edge, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef INTERARRIVAL_CV_WINDOW_DEFINES_SVH
`define INTERARRIVAL_CV_WINDOW_DEFINES_SVH

// same-cycle implication
`define IACV_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IACV_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/iacv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iacv_pkg
// Shared constants and types of the interarrival CV window block.
// ----------------------------------------------------------------------------
package iacv_pkg;

	localparam int MAX_INTERVALS_DEF = 4096;
	localparam int TIME_BITS_DEF     = 48;

	localparam int SUM_W       = 40;
	localparam int SQ_W        = 64;
	localparam int S2_W        = 2 * SUM_W;
	localparam int CFG_W       = 16;
	localparam int WIN_US_W    = 26;
	localparam int MS_TO_US    = 1000;
	localparam int FRAC2_W     = 32;
	localparam int CV_W        = 32;
	localparam int GAP_COUNT_W = 13;

	localparam logic [SUM_W-1:0] SUM_MAX         = '1;
	localparam logic [CFG_W-1:0] WINDOW_MS_RESET = 16'd1500;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = APB_ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_WINDOW_MS = 1'b0;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [QLVL_W-1:0] level;
		logic              empty;
	} q_stat_t;

endpackage

FILE: src/iacv_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iacv_front
// Event intake: window tracking, trade gaps, gap square and saturating sums.
// Pushes one set summary per emitting set into the queue.
// ----------------------------------------------------------------------------
module iacv_front import iacv_pkg::*; #(
	parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
	parameter int TIME_BITS     = TIME_BITS_DEF,
	localparam int CNT_W        = $clog2(MAX_INTERVALS + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [TIME_BITS-1:0] timestamp_us,
	input  logic                 is_trade,
	input  logic                 last_of_set,
	input  logic [WIN_US_W-1:0]  win_us,
	input  q_stat_t              q_stat,
	output logic                 push,
	output logic [CNT_W-1:0]     push_cnt,
	output logic [SUM_W-1:0]     push_sum,
	output logic [SQ_W-1:0]      push_sqs
);

	localparam int AW = ((TIME_BITS > SUM_W) ? TIME_BITS : SUM_W) + 1;

	logic                 accept;
	logic [1:0]           seen_q;
	logic                 closed_q;
	logic                 have_q;
	logic [TIME_BITS-1:0] prev_q;
	logic [TIME_BITS-1:0] lim_q;
	logic                 lim_ok_q;
	logic [CNT_W-1:0]     cnt_q;

	logic                 first;
	logic [1:0]           seen_nx;
	logic                 closed_nx;
	logic                 take;
	logic                 add;
	logic [CNT_W-1:0]     cnt_nx;
	logic                 emit;
	logic [TIME_BITS-1:0] gap;

	logic                 add_s1, last_s1, emit_s1;
	logic [TIME_BITS-1:0] gap_s1;
	logic [CNT_W-1:0]     cnt_s1;
	logic                 add_s2, last_s2, emit_s2;
	logic [TIME_BITS-1:0] gap_s2;
	logic [SQ_W-1:0]      sq_s2;
	logic [CNT_W-1:0]     cnt_s2;

	logic [31:0]          gap_lo;
	logic [SQ_W-1:0]      sq_prod;
	logic [SQ_W-1:0]      sq_nx;

	logic [SUM_W-1:0]     sum_q;
	logic [SQ_W-1:0]      sqs_q;
	logic [AW-1:0]        sum_tot;
	logic [SQ_W:0]        sqs_tot;
	logic [SUM_W-1:0]     sum_nx;
	logic [SQ_W-1:0]      sqs_nx;
	logic [QLVL_W:0]      pend;

	assign pend   = (QLVL_W + 1)'(q_stat.level) + (QLVL_W + 1)'(emit_s1)
	              + (QLVL_W + 1)'(emit_s2);
	assign busy   = pend >= (QLVL_W + 1)'(QUEUE_DEPTH);
	assign accept = start && !busy;

	always_comb begin
		first     = seen_q == 2'd0;
		seen_nx   = (seen_q == 2'd3) ? 2'd3 : seen_q + 2'd1;
		closed_nx = closed_q || (!first && lim_ok_q && (timestamp_us < lim_q));
		take      = !closed_nx && is_trade;
		gap       = (timestamp_us >= prev_q) ? timestamp_us - prev_q
		                                     : prev_q - timestamp_us;
		add       = take && have_q && (cnt_q < CNT_W'(MAX_INTERVALS));
		cnt_nx    = cnt_q + CNT_W'(add);
		emit      = last_of_set && (seen_nx == 2'd3) && (cnt_nx >= CNT_W'(2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q   <= 2'd0;
			closed_q <= 1'b0;
			have_q   <= 1'b0;
			lim_ok_q <= 1'b0;
			cnt_q    <= '0;
		end else if (accept) begin
			if (last_of_set) begin
				seen_q   <= 2'd0;
				closed_q <= 1'b0;
				have_q   <= 1'b0;
				lim_ok_q <= 1'b0;
				cnt_q    <= '0;
			end else begin
				seen_q   <= seen_nx;
				closed_q <= closed_nx;
				cnt_q    <= cnt_nx;
				if (take)
					have_q <= 1'b1;
				if (first)
					lim_ok_q <= timestamp_us > TIME_BITS'(win_us);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && take)
			prev_q <= timestamp_us;
		if (accept && first)
			lim_q <= timestamp_us - TIME_BITS'(win_us);
	end

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			add_s1  <= 1'b0;
			last_s1 <= 1'b0;
			emit_s1 <= 1'b0;
			add_s2  <= 1'b0;
			last_s2 <= 1'b0;
			emit_s2 <= 1'b0;
		end else begin
			add_s1  <= accept && add;
			last_s1 <= accept && last_of_set;
			emit_s1 <= accept && emit;
			add_s2  <= add_s1;
			last_s2 <= last_s1;
			emit_s2 <= emit_s1;
		end
	end

	assign gap_lo  = gap_s1[31:0];
	assign sq_prod = gap_lo * gap_lo;
	assign sq_nx   = (gap_s1 > TIME_BITS'(32'hFFFF_FFFF)) ? '1 : sq_prod;

	always_ff @(posedge clk) begin
		gap_s1 <= gap;
		cnt_s1 <= cnt_nx;
		gap_s2 <= gap_s1;
		sq_s2  <= sq_nx;
		cnt_s2 <= cnt_s1;
	end

	always_comb begin
		sum_tot = AW'(sum_q) + AW'(gap_s2);
		sqs_tot = {1'b0, sqs_q} + {1'b0, sq_s2};
		sum_nx  = sum_q;
		sqs_nx  = sqs_q;
		if (add_s2) begin
			sum_nx = (sum_tot > AW'(SUM_MAX)) ? SUM_MAX : sum_tot[SUM_W-1:0];
			sqs_nx = sqs_tot[SQ_W] ? '1 : sqs_tot[SQ_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			sqs_q <= '0;
		end else if (last_s2) begin
			sum_q <= '0;
			sqs_q <= '0;
		end else begin
			sum_q <= sum_nx;
			sqs_q <= sqs_nx;
		end
	end

	assign push     = emit_s2;
	assign push_cnt = cnt_s2;
	assign push_sum = sum_nx;
	assign push_sqs = sqs_nx;

endmodule

FILE: src/iacv_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iacv_fifo
// Short register queue of set summaries between intake and statistic engine.
// ----------------------------------------------------------------------------
`include "interarrival_cv_window_defines.svh"

module iacv_fifo import iacv_pkg::*; #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output q_stat_t          q_stat
);

	logic [WIDTH-1:0]  mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QLVL_W-1:0] level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
				                                                  : wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
				                                                  : rd_ptr_q + QPTR_W'(1);
			if (push && !pop)
				level_q <= level_q + QLVL_W'(1);
			else if (pop && !push)
				level_q <= level_q - QLVL_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	assign head         = mem_q[rd_ptr_q];
	assign q_stat.level = level_q;
	assign q_stat.empty = level_q == '0;

	`IACV_ASSERT_NOW(a_no_overflow, clk, arst_n, push, level_q != QLVL_W'(QUEUE_DEPTH), "queue overflow")
	`IACV_ASSERT_NOW(a_no_underflow, clk, arst_n, pop, level_q != '0, "queue underflow")
	`IACV_ASSERT_NEXT(a_level_up, clk, arst_n, push && !pop, level_q == $past(level_q) + QLVL_W'(1), "queue level not incremented")

endmodule

FILE: src/iacv_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iacv_back
// Statistic engine: shift-add products, restoring divide and bitwise square
// root on one set summary, giving the CV in Q16.16.
// ----------------------------------------------------------------------------
`include "interarrival_cv_window_defines.svh"

module iacv_back import iacv_pkg::*; #(
	parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
	localparam int CNT_W        = $clog2(MAX_INTERVALS + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  q_stat_t                q_stat,
	input  logic [CNT_W-1:0]       head_cnt,
	input  logic [SUM_W-1:0]       head_sum,
	input  logic [SQ_W-1:0]        head_sqs,
	output logic                   pop,
	output logic                   done,
	output logic [CV_W-1:0]        cv_q16,
	output logic [GAP_COUNT_W-1:0] gap_count
);

	localparam int MW   = CNT_W + SQ_W + ((CNT_W > 16) ? CNT_W : 16);
	localparam int DW   = CNT_W + S2_W;
	localparam int NUMW = MW + FRAC2_W;
	localparam int MPW  = (CNT_W > SUM_W) ? CNT_W : SUM_W;
	localparam int STW  = $clog2(NUMW + 1);

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_MNQ  = 9'b000000010,
		ST_MS2  = 9'b000000100,
		ST_CMP  = 9'b000001000,
		ST_MNUM = 9'b000010000,
		ST_MDEN = 9'b000100000,
		ST_DIV  = 9'b001000000,
		ST_SQRT = 9'b010000000,
		ST_OUT  = 9'b100000000
	} state_t;

	state_t            state_q, state_nx;
	logic [CNT_W-1:0]  n_q;
	logic [SUM_W-1:0]  s_q;
	logic [MW-1:0]     acc_q, mcand_q, nq_q;
	logic [MPW-1:0]    mplier_q;
	logic [S2_W-1:0]   s2_q;
	logic [NUMW-1:0]   div_q;
	logic [DW-1:0]     den_q, rem_q;
	logic [SQ_W-1:0]   quo_q;
	logic              ovf_q;
	logic [33:0]       srem_q;
	logic [31:0]       root_q;
	logic [STW-1:0]    step_q;
	logic [CV_W-1:0]   res_q;

	logic              mul_done;
	logic [MW-1:0]     acc_add;
	logic [DW:0]       rem_sh, rem_dif;
	logic              rem_ge;
	logic [35:0]       sq_sh, sq_trial, sq_dif;
	logic              sq_ge;
	logic              var_zero;

	assign pop      = (state_q == ST_IDLE) && !q_stat.empty;
	assign mul_done = mplier_q == '0;
	assign acc_add  = mplier_q[0] ? acc_q + mcand_q : acc_q;
	assign rem_sh   = {rem_q, div_q[NUMW-1]};
	assign rem_ge   = rem_sh >= {1'b0, den_q};
	assign rem_dif  = rem_sh - {1'b0, den_q};
	assign sq_sh    = {srem_q, quo_q[SQ_W-1 -: 2]};
	assign sq_trial = {2'b00, root_q, 2'b01};
	assign sq_ge    = sq_sh >= sq_trial;
	assign sq_dif   = sq_sh - sq_trial;
	assign var_zero = nq_q <= MW'(s2_q);

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (pop)
					state_nx = (head_sum == '0) ? ST_OUT : ST_MNQ;
			end
			ST_MNQ:  if (mul_done) state_nx = ST_MS2;
			ST_MS2:  if (mul_done) state_nx = ST_CMP;
			ST_CMP:  state_nx = var_zero ? ST_OUT : ST_MNUM;
			ST_MNUM: if (mul_done) state_nx = ST_MDEN;
			ST_MDEN: if (mul_done) state_nx = ST_DIV;
			ST_DIV: begin
				if (step_q == '0)
					state_nx = ovf_q ? ST_OUT : ST_SQRT;
			end
			ST_SQRT: if (step_q == '0) state_nx = ST_OUT;
			ST_OUT:  state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nx;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop) begin
					n_q      <= head_cnt;
					s_q      <= head_sum;
					acc_q    <= '0;
					mcand_q  <= MW'(head_sqs);
					mplier_q <= MPW'(head_cnt);
					res_q    <= '0;
				end
			end
			ST_MNQ: begin
				if (mul_done) begin
					nq_q     <= acc_q;
					acc_q    <= '0;
					mcand_q  <= MW'(s_q);
					mplier_q <= MPW'(s_q);
				end else begin
					acc_q    <= acc_add;
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
				end
			end
			ST_MS2: begin
				if (mul_done) begin
					s2_q <= acc_q[S2_W-1:0];
				end else begin
					acc_q    <= acc_add;
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
				end
			end
			ST_CMP: begin
				acc_q    <= '0;
				mcand_q  <= nq_q - MW'(s2_q);
				mplier_q <= MPW'(n_q);
			end
			ST_MNUM: begin
				if (mul_done) begin
					div_q    <= {acc_q, FRAC2_W'(0)};
					acc_q    <= '0;
					mcand_q  <= MW'(s2_q);
					mplier_q <= MPW'(n_q - CNT_W'(1));
				end else begin
					acc_q    <= acc_add;
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
				end
			end
			ST_MDEN: begin
				if (mul_done) begin
					den_q  <= acc_q[DW-1:0];
					rem_q  <= '0;
					quo_q  <= '0;
					ovf_q  <= 1'b0;
					step_q <= STW'(NUMW);
				end else begin
					acc_q    <= acc_add;
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
				end
			end
			ST_DIV: begin
				if (step_q == '0) begin
					res_q  <= '1;
					srem_q <= '0;
					root_q <= '0;
					step_q <= STW'(32);
				end else begin
					rem_q  <= rem_ge ? rem_dif[DW-1:0] : rem_sh[DW-1:0];
					quo_q  <= {quo_q[SQ_W-2:0], rem_ge};
					ovf_q  <= ovf_q || quo_q[SQ_W-1];
					div_q  <= div_q << 1;
					step_q <= step_q - STW'(1);
				end
			end
			ST_SQRT: begin
				if (step_q == '0) begin
					res_q <= root_q;
				end else begin
					srem_q <= sq_ge ? sq_dif[33:0] : sq_sh[33:0];
					root_q <= {root_q[30:0], sq_ge};
					quo_q  <= quo_q << 2;
					step_q <= step_q - STW'(1);
				end
			end
			default: ;
		endcase
	end

	assign done      = state_q == ST_OUT;
	assign cv_q16    = res_q;
	assign gap_count = GAP_COUNT_W'(n_q);

	`IACV_ASSERT_NOW(a_den_nonzero, clk, arst_n, state_q == ST_DIV, den_q != '0, "divisor is zero")
	`IACV_ASSERT_NOW(a_sqrt_in_range, clk, arst_n, state_q == ST_SQRT, !ovf_q, "root taken of an overflowed quotient")
	`IACV_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done, "result strobe longer than one cycle")

endmodule

FILE: src/interarrival_cv_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interarrival_cv_window
// Coefficient of variation of trade inter-arrival times over a look-back
// window, at most one result per set of events.
// ----------------------------------------------------------------------------
// Usage:
//   Events are presented newest first on timestamp_us / is_trade / last_of_set
//   and a transaction is taken at a clock edge with start high and busy low.
//   One event per cycle is sustained while busy is low; busy rises when set
//   summaries queued or still in the intake pipeline reach QUEUE_DEPTH.
//   After the event marked last_of_set, the set summary passes the s1 and s2
//   intake registers and is then queued; the engine computes the products,
//   the restoring divide and the square root one bit per cycle in each unit.
//   A result is shown for exactly one cycle with done high; the receiver
//   cannot stall, so it must take it then. Sets that emit nothing still flow
//   through the intake at one event per cycle while busy is low. Reset clears
//   all set state and the queue and loads window_ms with 1500. The user
//   writes window_ms over APB port address 0 only while idle; not enforced.
// ----------------------------------------------------------------------------
module interarrival_cv_window import iacv_pkg::*; #(
	parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
	parameter int TIME_BITS     = TIME_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [TIME_BITS-1:0]   timestamp_us,
	input  logic                   is_trade,
	input  logic                   last_of_set,
	output logic                   done,
	output logic [CV_W-1:0]        cv_q16,
	output logic [GAP_COUNT_W-1:0] gap_count,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [APB_ADDR_W-1:0]  paddr,
	input  logic [APB_DATA_W-1:0]  pwdata,
	output logic [APB_DATA_W-1:0]  prdata,
	output logic                   pready
);

	localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
	localparam int QW    = CNT_W + SUM_W + SQ_W;

	logic [CFG_W-1:0]     window_ms_q;
	logic [WIN_US_W-1:0]  win_us_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 cfg_wr;

	logic                 push, pop;
	logic [CNT_W-1:0]     push_cnt;
	logic [SUM_W-1:0]     push_sum;
	logic [SQ_W-1:0]      push_sqs;
	logic [QW-1:0]        head;
	q_stat_t              q_stat;

	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready && (reg_idx == REG_WINDOW_MS);
	assign prdata  = (reg_idx == REG_WINDOW_MS) ? APB_DATA_W'(window_ms_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_ms_q <= WINDOW_MS_RESET;
			win_us_q    <= WIN_US_W'(WINDOW_MS_RESET) * WIN_US_W'(MS_TO_US);
		end else if (cfg_wr) begin
			window_ms_q <= pwdata[CFG_W-1:0];
			win_us_q    <= WIN_US_W'(pwdata[CFG_W-1:0]) * WIN_US_W'(MS_TO_US);
		end
	end

	iacv_front #(
		.MAX_INTERVALS(MAX_INTERVALS),
		.TIME_BITS    (TIME_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.timestamp_us(timestamp_us),
		.is_trade    (is_trade),
		.last_of_set (last_of_set),
		.win_us      (win_us_q),
		.q_stat      (q_stat),
		.push        (push),
		.push_cnt    (push_cnt),
		.push_sum    (push_sum),
		.push_sqs    (push_sqs)
	);

	iacv_fifo #(
		.WIDTH(QW)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({push_cnt, push_sum, push_sqs}),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	iacv_back #(
		.MAX_INTERVALS(MAX_INTERVALS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.head_cnt (head[QW-1 -: CNT_W]),
		.head_sum (head[SQ_W +: SUM_W]),
		.head_sqs (head[SQ_W-1:0]),
		.pop      (pop),
		.done     (done),
		.cv_q16   (cv_q16),
		.gap_count(gap_count)
	);

endmodule

FILE: sim/tb_interarrival_cv_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_interarrival_cv_window
// Drives sets of market events into the block, newest first, and checks each
// coefficient-of-variation result against an exact integer predictor kept in
// the bench. Covers short sets, zero mean, window edges, oversized gaps,
// register writes and reads, then random sets under several window lengths
// with bursty start traffic.
// ----------------------------------------------------------------------------
module tb_interarrival_cv_window;
	import iacv_pkg::*;

	localparam int LIMIT_CYCLES = 4_000_000;
	localparam int DRAIN_CYCLES = 400;
	localparam int PHASE_ITEMS  = 285;
	localparam logic [APB_ADDR_W-1:0] ADDR_WINDOW_MS = {REG_WINDOW_MS, 2'b00};
	localparam logic [APB_ADDR_W-1:0] ADDR_SPARE     = {~REG_WINDOW_MS, 2'b00};

	typedef logic [TIME_BITS_DEF-1:0] ts_t;
	localparam ts_t TS_MAX = '1;

	typedef struct packed {
		logic [CV_W-1:0]        cv;
		logic [GAP_COUNT_W-1:0] n;
	} cv_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic                   busy;
	ts_t                    timestamp_us = '0;
	logic                   is_trade = 1'b0;
	logic                   last_of_set = 1'b0;
	logic                   done;
	logic [CV_W-1:0]        cv_q16;
	logic [GAP_COUNT_W-1:0] gap_count;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [APB_ADDR_W-1:0]  paddr = '0;
	logic [APB_DATA_W-1:0]  pwdata = '0;
	logic [APB_DATA_W-1:0]  prdata;
	logic                   pready;

	interarrival_cv_window u_top (.*);

	// predictor state
	logic [CFG_W-1:0] win_ms = WINDOW_MS_RESET;
	ts_t              set_end, last_trade_ts;
	bit               have_trade, set_closed;
	int unsigned      set_events, set_gaps;
	logic [SUM_W-1:0] gap_total;
	logic [SQ_W-1:0]  gap_sq_total;

	cv_result_t cv_expected[$];
	cv_result_t head;
	int         errors = 0;
	int         cycles = 0;
	int         items_sent = 0;
	int         burst_left = 0;
	bit         feeding = 0;

	initial forever #5 clk = ~clk;

	function automatic void clear_set_state();
		set_end = '0;
		last_trade_ts = '0;
		have_trade = 0;
		set_closed = 0;
		set_events = 0;
		set_gaps = 0;
		gap_total = '0;
		gap_sq_total = '0;
	endfunction

	// floor(65536 * sqrt(n*(n*Q - S*S) / ((n-1)*S*S))), saturating
	function automatic logic [CV_W-1:0] cv_of_gaps(int unsigned n, logic [SUM_W-1:0] s,
			logic [SQ_W-1:0] q);
		logic [191:0] nq, s2, num, den, quo;
		logic [63:0]  root, trial;
		if (s == 0)
			return '0;
		nq = 192'(n) * 192'(q);
		s2 = 192'(s) * 192'(s);
		if (nq <= s2)
			return '0;
		num = ((nq - s2) * 192'(n)) << 32;
		den = 192'(n - 1) * s2;
		quo = num / den;
		if (quo[191:64] != 0)
			return '1;
		root = '0;
		for (int b = 31; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= quo[63:0])
				root = trial;
		end
		return root[CV_W-1:0];
	endfunction

	function automatic void track_event(ts_t ts, logic trade, logic last);
		logic [63:0] win_us, gap, sq;
		cv_result_t  r;
		win_us = 64'(win_ms) * 64'd1000;
		if (set_events == 0)
			set_end = ts;
		if (set_events < 3)
			set_events++;
		if (!set_closed && 64'(set_end) > win_us && 64'(ts) < 64'(set_end) - win_us)
			set_closed = 1;
		if (!set_closed && trade) begin
			if (have_trade) begin
				gap = (ts >= last_trade_ts) ? 64'(ts - last_trade_ts) : 64'(last_trade_ts - ts);
				if (set_gaps < MAX_INTERVALS_DEF) begin
					sq = (gap > 64'hFFFF_FFFF) ? '1 : gap * gap;
					gap_total = (gap > 64'(SUM_MAX - gap_total)) ? SUM_MAX
						: gap_total + SUM_W'(gap);
					gap_sq_total = (sq > ~gap_sq_total) ? '1 : gap_sq_total + sq;
					set_gaps++;
				end
			end
			last_trade_ts = ts;
			have_trade = 1;
		end
		if (last) begin
			if (set_events >= 3 && set_gaps >= 2) begin
				r.cv = cv_of_gaps(set_gaps, gap_total, gap_sq_total);
				r.n = GAP_COUNT_W'(set_gaps);
				cv_expected.push_back(r);
			end
			clear_set_state();
		end
	endfunction

	function automatic ts_t rand_ts();
		return ts_t'({$urandom, $urandom});
	endfunction

	// one event transaction; start stays high through a burst
	task automatic send_event(ts_t ts, logic trade, logic last);
		start <= 1'b1;
		timestamp_us <= ts;
		is_trade <= trade;
		last_of_set <= last;
		feeding = 1;
		do @(posedge clk); while (busy);
		track_event(ts, trade, last);
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			feeding = 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 250)
				: $urandom_range(0, 11);
		end
	endtask

	task automatic wait_drained();
		if (feeding) begin
			start <= 1'b0;
			feeding = 0;
		end
		while (cv_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_WINDOW_MS)
			win_ms = data[CFG_W-1:0];
		@(posedge clk);
	endtask

	task automatic cfg_read_check();
		psel <= 1'b1;
		paddr <= ADDR_WINDOW_MS;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== APB_DATA_W'(win_ms)) begin
			$error("window_ms readback expected %0d got %0d", win_ms, prdata);
			errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_short_sets();
		send_event(48'd777, 1'b1, 1'b1);
		send_event(48'd900, 1'b1, 1'b0);
		send_event(48'd800, 1'b1, 1'b1);
		// three events, one gap
		send_event(48'd700, 1'b1, 1'b0);
		send_event(48'd650, 1'b0, 1'b0);
		send_event(48'd600, 1'b1, 1'b1);
		send_event(48'd500, 1'b1, 1'b0);
		send_event(48'd470, 1'b1, 1'b0);
		send_event(48'd400, 1'b1, 1'b1);
	endtask

	task automatic test_zero_mean();
		for (int i = 0; i < 4; i++)
			send_event(TS_MAX, 1'b1, i == 3);
	endtask

	task automatic test_window_edges();
		// window start below time zero
		send_event(48'd1000, 1'b1, 1'b0);
		send_event(48'd500, 1'b1, 1'b0);
		send_event(48'd0, 1'b1, 1'b0);
		send_event(48'd0, 1'b1, 1'b1);
		// exact window edge stays open, one below closes it
		send_event(48'd10_000_000, 1'b1, 1'b0);
		send_event(48'd9_999_000, 1'b1, 1'b0);
		send_event(48'd8_500_000, 1'b1, 1'b0);
		send_event(48'd8_499_999, 1'b1, 1'b0);
		send_event(48'd8_000_000, 1'b1, 1'b1);
	endtask

	task automatic test_oversized_gaps();
		// newer than end, square and sums saturate
		send_event(48'd0, 1'b1, 1'b0);
		send_event(TS_MAX, 1'b1, 1'b0);
		send_event(48'd0, 1'b1, 1'b0);
		send_event(TS_MAX, 1'b1, 1'b1);
		// largest gap whose square still fits
		send_event(48'd0, 1'b1, 1'b0);
		send_event(48'hFFFF_FFFF, 1'b1, 1'b0);
		send_event(48'h1_FFFF_FFFE, 1'b1, 1'b1);
	endtask

	task automatic test_config();
		wait_drained();
		cfg_read_check();
		cfg_write(ADDR_WINDOW_MS, '0);
		cfg_read_check();
		send_event(48'd5000, 1'b1, 1'b0);
		send_event(48'd5000, 1'b1, 1'b0);
		send_event(48'd5000, 1'b1, 1'b0);
		send_event(48'd4999, 1'b1, 1'b1);
		wait_drained();
		cfg_write(ADDR_SPARE, 32'h0000_BEEF);
		cfg_read_check();
		cfg_write(ADDR_WINDOW_MS, 32'd60000);
		cfg_read_check();
	endtask

	task automatic random_set();
		int          len, pick;
		ts_t         t, end_ts;
		logic [63:0] win_us, step;
		win_us = 64'(win_ms) * 64'd1000;
		if ($urandom_range(0, 99) < 12) begin
			len = $urandom_range(1, 3);
			for (int i = 0; i < len; i++)
				send_event(rand_ts(), 1'($urandom_range(0, 1)), i == len - 1);
			return;
		end
		len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 60) : $urandom_range(3, 16);
		case ($urandom_range(0, 5))
			0: t = ts_t'($urandom_range(0, 3000));
			1: t = TS_MAX - ts_t'($urandom_range(0, 3000));
			default: t = rand_ts();
		endcase
		end_ts = t;
		for (int i = 0; i < len; i++) begin
			send_event(t, 1'($urandom_range(0, 4) != 0), i == len - 1);
			pick = $urandom_range(0, 99);
			if (pick < 50)
				step = $urandom_range(0, 2000);
			else if (pick < 75)
				step = $urandom_range(0, 32'(win_us / len) + 1);
			else if (pick < 85)
				step = 0;
			else if (pick < 93)
				step = {$urandom, $urandom} >> $urandom_range(8, 40);
			else
				step = 64'hFFFF_FFFF + $urandom_range(0, 2);
			if (pick >= 70 && pick < 75 && 64'(end_ts) > win_us)
				t = ts_t'(64'(end_ts) - win_us - 64'($urandom_range(0, 1)));
			else if ($urandom_range(0, 9) == 0)
				t = t + ts_t'(step);
			else
				t = (64'(t) >= step) ? t - ts_t'(step) : '0;
		end
	endtask

	task automatic test_random();
		int windows[6];
		int mark;
		windows = '{60000, 0, 1, $urandom_range(2, 59999), 1500, $urandom_range(0, 60000)};
		foreach (windows[p]) begin
			wait_drained();
			cfg_write(ADDR_WINDOW_MS, APB_DATA_W'(windows[p]));
			cfg_read_check();
			mark = items_sent;
			while (items_sent - mark < PHASE_ITEMS)
				random_set();
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (cv_expected.size() == 0) begin
				$error("unexpected result cv_q16 %0d gap_count %0d", cv_q16, gap_count);
				errors++;
			end else begin
				head = cv_expected.pop_front();
				if (cv_q16 !== head.cv) begin
					$error("cv_q16 expected %0d got %0d", head.cv, cv_q16);
					errors++;
				end
				if (gap_count !== head.n) begin
					$error("gap_count expected %0d got %0d", head.n, gap_count);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("tb_interarrival_cv_window: errors");
			$finish;
		end
	end

	initial begin
		clear_set_state();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_short_sets();
		test_zero_mean();
		test_window_edges();
		test_oversized_gaps();
		test_config();
		test_random();
		wait_drained();
		if (errors == 0)
			$display("tb_interarrival_cv_window: clean");
		else
			$display("tb_interarrival_cv_window: errors");
		$finish;
	end

endmodule
